### rtl/dsq_pkg.sv
// Package for the date sorted priority queue: sizes, item types, codes
// and the small helper functions used by the control.
// No dependencies.
package dsq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_BITS = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [5:0] DAY_MAX   = 6'd31;
  localparam logic [7:0] NAME_MAX  = 8'd12;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] entry_handle;
    logic [3:0]  due_month;
    logic [5:0]  due_day;
    logic [7:0]  name_length;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        out_valid;
    logic [15:0] out_handle;
    logic [3:0]  out_month;
    logic [5:0]  out_day;
    logic [4:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [3:0]             month;
    logic [4:0]             day;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic busy;
    logic done;
  } ctrl_stat_t;

  // physical slot of logical offset ofs from the ring head
  function automatic logic [IDX_W-1:0] idx_wrap(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // stored date strictly later than the new date
  function automatic logic date_after(input logic [3:0] sm, input logic [4:0] sd,
                                      input logic [3:0] nm, input logic [4:0] nd);
    if (sm != nm) begin
      return sm > nm;
    end
    return sd > nd;
  endfunction

endpackage

### rtl/dsq_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module dsq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/dsq_ctrl.sv
// Queue sequencer: ring pointers, insertion scan and dequeue over the slot RAM.
// Depends on dsq_pkg and dsq_ram.
module dsq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  dsq_pkg::in_item_t  item,
  input  logic               out_free,
  output dsq_pkg::ctrl_stat_t stat,
  output dsq_pkg::out_item_t res
);
  import dsq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_SCAN  = 5'b00100,
    S_PLACE = 5'b01000,
    S_DEQ   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;

  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  slot_t             wr_data, rd_slot;
  logic [SLOT_W-1:0] rd_raw;

  slot_t             new_slot;
  logic              enq_ok;
  logic [IDX_W-1:0]  last_l;

  dsq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(SLOT_W)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_slot = slot_t'(rd_raw);

  always_comb begin
    new_slot.handle = HANDLE_BITS'(item_r.entry_handle);
    new_slot.month  = item_r.due_month;
    new_slot.day    = item_r.due_day[4:0];
    enq_ok = (item_r.due_month >= 4'd1) && (item_r.due_month <= MONTH_MAX) &&
             (item_r.due_day >= 6'd1) && (item_r.due_day <= DAY_MAX) &&
             (item_r.name_length >= 8'd1) && (item_r.name_length <= NAME_MAX) &&
             (count_r < CNT_W'(QUEUE_DEPTH));
    last_l = IDX_W'(count_r - CNT_W'(1));
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = new_slot;
    stat.busy = (state_r != S_IDLE);
    stat.done = 1'b0;
    res       = '0;
    res.occupancy = 5'(count_r);

    case (state_r)
      S_IDLE: begin
        if (go) begin
          item_nxt  = item;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (item_r.cmd == CMD_ENQ) begin
          if (!enq_ok) begin
            if (out_free) begin
              stat.done = 1'b1;
              state_nxt = S_IDLE;
            end
          end else if (count_r == '0) begin
            if (out_free) begin
              wr_en         = 1'b1;
              wr_addr       = head_r;
              count_nxt     = count_r + CNT_W'(1);
              stat.done     = 1'b1;
              res.accepted  = 1'b1;
              res.occupancy = 5'(count_nxt);
              state_nxt     = S_IDLE;
            end
          end else begin
            // walk back from the tail
            rd_en     = 1'b1;
            rd_addr   = idx_wrap(head_r, last_l);
            pos_nxt   = IDX_W'(count_r);
            state_nxt = S_SCAN;
          end
        end else begin
          if (count_r == '0) begin
            if (out_free) begin
              stat.done = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            rd_en     = 1'b1;
            rd_addr   = head_r;
            state_nxt = S_DEQ;
          end
        end
      end
      S_SCAN: begin
        // rd_slot is the entry at logical pos_r - 1
        if (date_after(rd_slot.month, rd_slot.day, new_slot.month, new_slot.day)) begin
          wr_en   = 1'b1;
          wr_addr = idx_wrap(head_r, pos_r);
          wr_data = rd_slot;
          pos_nxt = pos_r - IDX_W'(1);
          if (pos_r > IDX_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = idx_wrap(head_r, pos_r - IDX_W'(1) - IDX_W'(1));
          end else begin
            state_nxt = S_PLACE;
          end
        end else if (out_free) begin
          wr_en         = 1'b1;
          wr_addr       = idx_wrap(head_r, pos_r);
          count_nxt     = count_r + CNT_W'(1);
          stat.done     = 1'b1;
          res.accepted  = 1'b1;
          res.occupancy = 5'(count_nxt);
          state_nxt     = S_IDLE;
        end
      end
      S_PLACE: begin
        if (out_free) begin
          wr_en         = 1'b1;
          wr_addr       = idx_wrap(head_r, pos_r);
          count_nxt     = count_r + CNT_W'(1);
          stat.done     = 1'b1;
          res.accepted  = 1'b1;
          res.occupancy = 5'(count_nxt);
          state_nxt     = S_IDLE;
        end
      end
      S_DEQ: begin
        if (out_free) begin
          stat.done      = 1'b1;
          res.out_valid  = 1'b1;
          res.out_handle = 16'(rd_slot.handle);
          res.out_month  = rd_slot.month;
          res.out_day    = {1'b0, rd_slot.day};
          head_nxt       = idx_wrap(head_r, IDX_W'(1));
          count_nxt      = count_r - CNT_W'(1);
          res.occupancy  = 5'(count_nxt);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

### rtl/date_sorted_priority_queue.sv
// Date sorted priority queue, top level: input channel, result register.
// Depends on dsq_pkg and dsq_ctrl.
//
// Holds up to QUEUE_DEPTH entries in a ring of RAM slots kept sorted by
// (month, day); equal dates leave in arrival order. Every command item
// gives exactly one result item. The block takes one item at a time:
// a rejected enqueue or a dequeue from an empty queue ends in the start
// state, a dequeue adds one RAM read, and an accepted enqueue walks back
// from the tail past each held entry with a later date, moving one slot
// per cycle through the single RAM read and write port, and then writes
// the new entry (from the start state into an empty queue). A result
// waits in the output register while the next item is already taken in;
// a held result only delays the final step of the following item.
module date_sorted_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dsq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output dsq_pkg::out_item_t out_item
);
  import dsq_pkg::*;

  ctrl_stat_t stat;
  out_item_t  res;
  out_item_t  res_r;
  logic       res_vld_r;
  logic       out_free;
  logic       go;

  // the sequencer only takes an item when idle
  assign in_stall = stat.busy;
  assign go       = in_valid && !stat.busy;

  // output register is free when empty or being drained this cycle
  assign out_free = !res_vld_r || !out_stall;

  dsq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .item     (in_item),
    .out_free (out_free),
    .stat     (stat),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (stat.done) begin
      res_vld_r <= 1'b1;
    end else if (!out_stall) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      res_r <= res;
    end
  end

  assign out_valid = res_vld_r;
  assign out_item  = res_r;

endmodule
